// File: rtl/core/mtbl_pkg.sv
// Shared types and constants for the monotonic table bisection locate block.
// No dependencies.
package mtbl_pkg;

    localparam int VAL_W = 32;
    localparam int IDX_PORT_W = 10;
    localparam int LEN_W = 11;

    localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;
    localparam logic signed [VAL_W-1:0] NO_DATA_CODE = 32'sh8000_0000;

    typedef enum logic
    {
        OP_WRITE  = 1'b0,
        OP_SEARCH = 1'b1
    } opcode_t;

endpackage

// File: rtl/core/mtbl_mem.sv
// Table memory: one write port, one read port, registered read data.
// Depends on mtbl_pkg.
module mtbl_mem #(
    parameter int DEPTH = 1024,
    parameter int AW = 10
) (
    input  logic                               clk,
    input  logic                               we,
    input  logic [AW-1:0]                      waddr,
    input  logic signed [mtbl_pkg::VAL_W-1:0]  wdata,
    input  logic                               re,
    input  logic [AW-1:0]                      raddr,
    output logic signed [mtbl_pkg::VAL_W-1:0]  rdata
);
    import mtbl_pkg::*;

    logic signed [VAL_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/core/mtbl_search.sv
// Command decode and bisection sequencer; drives the table memory ports.
// Depends on mtbl_pkg.
module mtbl_search #(
    parameter int DEPTH = 1024,
    parameter int AW = 10
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  mtbl_pkg::opcode_t                    opcode,
    input  logic [mtbl_pkg::IDX_PORT_W-1:0]      entry_index,
    input  logic signed [mtbl_pkg::VAL_W-1:0]    value,
    input  logic [mtbl_pkg::LEN_W-1:0]           length,
    output logic                                 done,
    output logic                                 found,
    output logic [mtbl_pkg::IDX_PORT_W-1:0]      interval_index,
    output logic                                 mem_we,
    output logic [AW-1:0]                        mem_waddr,
    output logic signed [mtbl_pkg::VAL_W-1:0]    mem_wdata,
    output logic                                 mem_re,
    output logic [AW-1:0]                        mem_raddr,
    input  logic signed [mtbl_pkg::VAL_W-1:0]    mem_rdata
);
    import mtbl_pkg::*;

    localparam int CW = (AW + 1 > LEN_W) ? AW + 1 : LEN_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    typedef enum logic [2:0]
    {
        IDLE,
        RD_FIRST,
        RD_LAST,
        CHECK,
        BISECT
    } state_t;

    state_t                  state_reg, state_next;
    logic signed [VAL_W-1:0] key_reg, key_next;
    logic signed [VAL_W-1:0] first_reg, first_next;
    logic                    incr_reg, incr_next;
    logic [AW-1:0]           lo_reg, lo_next;
    logic [AW-1:0]           hi_reg, hi_next;
    logic [AW-1:0]           mid_reg, mid_next;
    logic                    done_reg, done_next;
    logic                    found_reg, found_next;
    logic [IDX_PORT_W-1:0]   idx_reg, idx_next;

    logic [CW-1:0] len_ext;
    logic [CW-1:0] eidx_ext;
    logic [AW-1:0] hi_init;
    logic          out_of_range;
    logic          key_gt;
    logic [AW-1:0] lo_b, hi_b;
    logic [AW:0]   sum_c, sum_b;
    logic [CW-1:0] lo_b_ext;

    assign len_ext  = CW'(length);
    assign eidx_ext = CW'(entry_index);
    assign hi_init  = (len_ext >= DEPTH_C) ? AW'(DEPTH - 1) : AW'(len_ext - 1'b1);

    assign sum_c = {1'b0, lo_reg} + {1'b0, hi_reg};

    always_comb
    begin
        key_gt = key_reg > mem_rdata;
        if (incr_reg == key_gt)
        begin
            lo_b = mid_reg;
            hi_b = hi_reg;
        end
        else
        begin
            lo_b = lo_reg;
            hi_b = mid_reg;
        end
        sum_b    = {1'b0, lo_b} + {1'b0, hi_b};
        lo_b_ext = CW'(lo_b);
    end

    assign mem_we    = (state_reg == IDLE) && start && (opcode == OP_WRITE)
                       && (eidx_ext < DEPTH_C);
    assign mem_waddr = eidx_ext[AW-1:0];
    assign mem_wdata = value;

    always_comb
    begin
        state_next   = state_reg;
        key_next     = key_reg;
        first_next   = first_reg;
        incr_next    = incr_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        done_next    = 1'b0;
        found_next   = found_reg;
        idx_next     = idx_reg;
        mem_re       = 1'b0;
        mem_raddr    = '0;
        out_of_range = 1'b0;

        unique case (state_reg)
            IDLE:
            begin
                if (start && (opcode == OP_SEARCH))
                begin
                    key_next = value;
                    lo_next  = '0;
                    hi_next  = hi_init;
                    if ((value == NO_DATA_CODE) || (length == '0))
                    begin
                        done_next  = 1'b1;
                        found_next = 1'b0;
                        idx_next   = '0;
                    end
                    else
                    begin
                        state_next = RD_FIRST;
                    end
                end
            end
            RD_FIRST:
            begin
                mem_re     = 1'b1;
                mem_raddr  = '0;
                state_next = RD_LAST;
            end
            RD_LAST:
            begin
                mem_re     = 1'b1;
                mem_raddr  = hi_reg;
                first_next = mem_rdata;
                state_next = CHECK;
            end
            CHECK:
            begin
                // mem_rdata holds the last entry in use
                incr_next = mem_rdata > first_reg;
                if (mem_rdata > first_reg)
                begin
                    out_of_range = (first_reg > key_reg) || (key_reg > mem_rdata);
                end
                else
                begin
                    out_of_range = (key_reg > first_reg) || (mem_rdata > key_reg);
                end
                if (out_of_range)
                begin
                    done_next  = 1'b1;
                    found_next = 1'b0;
                    idx_next   = '0;
                    state_next = IDLE;
                end
                else if ((hi_reg - lo_reg) <= AW'(1))
                begin
                    done_next  = 1'b1;
                    found_next = 1'b1;
                    idx_next   = '0;
                    state_next = IDLE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = sum_c[AW:1];
                    mid_next   = sum_c[AW:1];
                    state_next = BISECT;
                end
            end
            BISECT:
            begin
                lo_next = lo_b;
                hi_next = hi_b;
                if ((hi_b - lo_b) > AW'(1))
                begin
                    mem_re    = 1'b1;
                    mem_raddr = sum_b[AW:1];
                    mid_next  = sum_b[AW:1];
                end
                else
                begin
                    done_next  = 1'b1;
                    found_next = 1'b1;
                    idx_next   = lo_b_ext[IDX_PORT_W-1:0];
                    state_next = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            done_reg  <= 1'b0;
            found_reg <= 1'b0;
            idx_reg   <= '0;
            key_reg   <= '0;
            first_reg <= '0;
            incr_reg  <= 1'b0;
            lo_reg    <= '0;
            hi_reg    <= '0;
            mid_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            found_reg <= found_next;
            idx_reg   <= idx_next;
            key_reg   <= key_next;
            first_reg <= first_next;
            incr_reg  <= incr_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            mid_reg   <= mid_next;
        end
    end

    assign busy           = (state_reg != IDLE);
    assign done           = done_reg;
    assign found          = found_reg;
    assign interval_index = idx_reg;

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("table write and read in the same cycle");

    a_miss_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> (interval_index == '0))
        else $error("not-found result with nonzero index");

    a_bisect_bracket: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BISECT) |-> ((mid_reg > lo_reg) && (hi_reg > mid_reg)))
        else $error("bisection midpoint outside bracket");

    a_done_after_search: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) != IDLE) || $past(start && (opcode == OP_SEARCH)))
        else $error("result strobe without a search");

endmodule

// File: rtl/core/monotonic_table_bisection_locate.sv
// Top level of the monotonic table bisection locate block.
// Depends on mtbl_pkg, mtbl_mem and mtbl_search.
//
// Usage:
//   Commands transfer at a rising edge with start high and busy low.
//   opcode OP_WRITE stores value at entry_index (indices at or beyond
//   TABLE_DEPTH are dropped); it raises no busy and no result. opcode
//   OP_SEARCH looks up the key in value and returns one result: done
//   pulses for one cycle with found and interval_index. Searches run one
//   at a time: busy is high until the result cycle. A no-data key or zero
//   length is answered from idle with no memory read; otherwise two
//   end-entry reads and a range check come first, then one memory read
//   per bisection step, ceil(log2(n - 1)) steps for n = min(length,
//   TABLE_DEPTH) entries in use (none for one or two entries or a key out
//   of range). Each step needs the previous step's read data from the
//   single read port of the table memory. table_length is written through
//   table_length_we; the user must keep that write to idle periods, as
//   the block leaves it to the user. Reset clears the sequencer and sets
//   table_length to 1024; table contents are undefined until written.
//   The receiver cannot stall.
module monotonic_table_bisection_locate #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  mtbl_pkg::opcode_t                  opcode,
    input  logic [mtbl_pkg::IDX_PORT_W-1:0]    entry_index,
    input  logic signed [mtbl_pkg::VAL_W-1:0]  value,
    input  logic                               table_length_we,
    input  logic [mtbl_pkg::LEN_W-1:0]         table_length,
    output logic                               done,
    output logic                               found,
    output logic [mtbl_pkg::IDX_PORT_W-1:0]    interval_index
);
    import mtbl_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    logic [LEN_W-1:0]        length_reg;
    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic signed [VAL_W-1:0] mem_wdata;
    logic                    mem_re;
    logic [AW-1:0]           mem_raddr;
    logic signed [VAL_W-1:0] mem_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= LEN_RESET;
        end
        else if (table_length_we)
        begin
            length_reg <= table_length;
        end
    end

    mtbl_search #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_search (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .opcode         (opcode),
        .entry_index    (entry_index),
        .value          (value),
        .length         (length_reg),
        .done           (done),
        .found          (found),
        .interval_index (interval_index),
        .mem_we         (mem_we),
        .mem_waddr      (mem_waddr),
        .mem_wdata      (mem_wdata),
        .mem_re         (mem_re),
        .mem_raddr      (mem_raddr),
        .mem_rdata      (mem_rdata)
    );

    mtbl_mem #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

// File: sim/tb_top.sv
// Self-checking bench for monotonic_table_bisection_locate: loads monotonic tables,
// runs bisection searches against a local predictor and checks every answer.
// Depends on mtbl_pkg and the monotonic_table_bisection_locate RTL.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import mtbl_pkg::*;

    localparam int TABLE_DEPTH = 1024;
    localparam int HALF_PERIOD = 5;
    localparam int ITEM_TARGET = 1350;
    localparam int BIG_LOAD_AT = 120;
    localparam int CFG_QUIET = 16;
    localparam int END_CYCLES = 20;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;
    localparam int GAP_PERCENT = 20;
    localparam int NO_GAP_FIRST = 300;
    localparam int NO_GAP_LAST = 700;
    localparam logic signed [VAL_W-1:0] MAX_CODE = 32'sh7fff_ffff;

    typedef enum logic [1:0]
    {
        CMD_ITEM,
        CMD_TABLE_LEN,
        CMD_DRAIN
    } cmd_kind_t;

    typedef struct packed
    {
        cmd_kind_t                  kind;
        opcode_t                    op;
        logic [IDX_PORT_W-1:0]      idx;
        logic signed [VAL_W-1:0]    val;
        logic [LEN_W-1:0]           len;
    } cmd_t;

    typedef struct packed
    {
        logic signed [VAL_W-1:0]    key;
        logic                       hit;
        logic [IDX_PORT_W-1:0]      pos;
    } answer_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    opcode_t                    opcode = OP_WRITE;
    logic [IDX_PORT_W-1:0]      entry_index = '0;
    logic signed [VAL_W-1:0]    value = '0;
    logic                       table_length_we = 1'b0;
    logic [LEN_W-1:0]           table_length = LEN_RESET;
    logic                       done;
    logic                       found;
    logic [IDX_PORT_W-1:0]      interval_index;

    cmd_t                       pending_cmds[$];
    answer_t                    expected_answers[$];

    // predictor state, advanced as transfers are accepted
    logic signed [VAL_W-1:0]    shadow_table [TABLE_DEPTH];
    logic [LEN_W-1:0]           shadow_length = LEN_RESET;

    // stimulus planning state, advanced as commands are queued
    logic signed [VAL_W-1:0]    plan_table [TABLE_DEPTH];
    bit                         plan_written [TABLE_DEPTH];
    int                         plan_length = LEN_RESET;
    int                         plan_items = 0;

    int unsigned                searches_sent = 0;
    int unsigned                answers_seen = 0;
    int                         error_count = 0;
    int                         stall_cycles = 0;

    monotonic_table_bisection_locate #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .opcode(opcode),
        .entry_index(entry_index),
        .value(value),
        .table_length_we(table_length_we),
        .table_length(table_length),
        .done(done),
        .found(found),
        .interval_index(interval_index)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
        begin
            $display("ERROR @%0t: %s", $time, msg);
        end
    endtask

    function automatic answer_t locate_interval(input logic signed [VAL_W-1:0] key);
        answer_t     a;
        int unsigned n;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        logic        rising;
        a.key = key;
        a.hit = 1'b0;
        a.pos = '0;
        if (key == NO_DATA_CODE || shadow_length == 0)
        begin
            return a;
        end
        n = (shadow_length > TABLE_DEPTH) ? TABLE_DEPTH : shadow_length;
        lo = 0;
        hi = n - 1;
        rising = shadow_table[hi] > shadow_table[0];
        if (rising ? (key < shadow_table[0] || key > shadow_table[hi])
                   : (key > shadow_table[0] || key < shadow_table[hi]))
        begin
            return a;
        end
        while (hi - lo > 1)
        begin
            mid = (lo + hi) >> 1;
            if ((key > shadow_table[mid]) == rising)
            begin
                lo = mid;
            end
            else
            begin
                hi = mid;
            end
        end
        a.hit = 1'b1;
        a.pos = lo[IDX_PORT_W-1:0];
        return a;
    endfunction

    function automatic logic signed [VAL_W-1:0] clamp_code(input longint v);
        if (v > longint'(MAX_CODE))
        begin
            return MAX_CODE;
        end
        if (v < longint'(NO_DATA_CODE))
        begin
            return NO_DATA_CODE;
        end
        return v[VAL_W-1:0];
    endfunction

    function automatic int plan_span();
        return (plan_length > TABLE_DEPTH) ? TABLE_DEPTH : plan_length;
    endfunction

    // a search may only touch entries already written
    function automatic bit plan_reads_ok();
        int n;
        n = plan_span();
        for (int i = 0; i < n; i++)
        begin
            if (!plan_written[i])
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_key();
        int                      n;
        int                      i;
        logic signed [VAL_W-1:0] lo_end;
        logic signed [VAL_W-1:0] hi_end;
        n = plan_span();
        if (n == 0)
        begin
            return $urandom_range(0, 1) ? NO_DATA_CODE : $urandom;
        end
        i = $urandom_range(0, n - 1);
        lo_end = plan_table[0];
        hi_end = plan_table[n-1];
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return plan_table[i];
            4, 5: return clamp_code(longint'(plan_table[i]) + ($urandom_range(0, 1) ? 1 : -1));
            6:
            begin
                case ($urandom_range(0, 3))
                    0: return clamp_code(longint'(lo_end) - 1);
                    1: return clamp_code(longint'(lo_end) + 1);
                    2: return clamp_code(longint'(hi_end) - 1);
                    default: return clamp_code(longint'(hi_end) + 1);
                endcase
            end
            7:
            begin
                case ($urandom_range(0, 2))
                    0: return NO_DATA_CODE;
                    1: return MAX_CODE;
                    default: return NO_DATA_CODE + 1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic push_item(input opcode_t op, input int idx, input logic signed [VAL_W-1:0] v);
        cmd_t c;
        c.kind = CMD_ITEM;
        c.op = op;
        c.idx = idx[IDX_PORT_W-1:0];
        c.val = v;
        c.len = '0;
        pending_cmds.push_back(c);
        plan_items++;
        if (op == OP_WRITE)
        begin
            plan_table[c.idx] = v;
            plan_written[c.idx] = 1'b1;
        end
    endtask

    task automatic push_search(input logic signed [VAL_W-1:0] key);
        logic signed [VAL_W-1:0] k;
        k = plan_reads_ok() ? key : NO_DATA_CODE;
        push_item(OP_SEARCH, $urandom_range(0, TABLE_DEPTH - 1), k);
    endtask

    task automatic push_ctrl(input cmd_kind_t kind, input int len);
        cmd_t c;
        c.kind = kind;
        c.op = OP_WRITE;
        c.idx = '0;
        c.val = '0;
        c.len = len[LEN_W-1:0];
        pending_cmds.push_back(c);
        if (kind == CMD_TABLE_LEN)
        begin
            plan_length = len;
        end
    endtask

    // style: 0 narrow with repeats, 1 wide, 2 wide with extreme ends, 3 flat, else medium
    task automatic load_table(input int n, input bit falling, input int style);
        logic signed [VAL_W-1:0] rising_vals [TABLE_DEPTH];
        longint                  v;
        longint                  step_max;
        int                      offset;
        int                      k;
        case (style)
            0:
            begin
                v = longint'($urandom_range(0, 2000)) - 1000;
                step_max = 3;
            end
            1, 2:
            begin
                v = longint'(NO_DATA_CODE) + $urandom_range(0, 1000);
                step_max = 64'd4294966000 / ((n > 1) ? n - 1 : 1);
            end
            3:
            begin
                v = longint'($signed($urandom));
                step_max = 0;
            end
            default:
            begin
                v = longint'($urandom_range(0, 1 << 30)) - (1 << 29);
                step_max = $urandom_range(1, 1 << 20);
            end
        endcase
        for (int i = 0; i < n; i++)
        begin
            if (i > 0)
            begin
                v = v + longint'($urandom_range(0, step_max[31:0]));
            end
            rising_vals[i] = v[VAL_W-1:0];
        end
        if (style == 2)
        begin
            rising_vals[0] = NO_DATA_CODE;
            rising_vals[n-1] = MAX_CODE;
        end
        offset = $urandom_range(0, n - 1);
        for (int i = 0; i < n; i++)
        begin
            k = (i + offset) % n;
            push_item(OP_WRITE, k, falling ? rising_vals[n-1-k] : rising_vals[k]);
        end
    endtask

    task automatic search_burst(input int count);
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 39))
                0: push_item(OP_WRITE, $urandom_range(0, TABLE_DEPTH - 1), $urandom);
                1: push_ctrl(CMD_DRAIN, 0);
                default: ;
            endcase
            push_search(pick_key());
        end
    endtask

    always @(posedge clk)
    begin : drive_seq
        cmd_t    nxt;
        logic    nstart;
        logic    nwe;
        bit      gap_ok;
        int      items_sent;
        int      quiet_cycles;
        if (rst_n)
        begin
            nstart = start;
            nwe = 1'b0;
            if (start && !busy)
            begin
                if (opcode == OP_WRITE)
                begin
                    shadow_table[entry_index] = value;
                end
                else
                begin
                    expected_answers.push_back(locate_interval(value));
                    searches_sent <= searches_sent + 1;
                end
                items_sent++;
                nstart = 1'b0;
            end
            if (start || table_length_we || searches_sent != answers_seen)
            begin
                quiet_cycles = 0;
            end
            else if (quiet_cycles < CFG_QUIET)
            begin
                quiet_cycles++;
            end
            if (!nstart && pending_cmds.size() != 0)
            begin
                nxt = pending_cmds[0];
                gap_ok = items_sent < NO_GAP_FIRST || items_sent >= NO_GAP_LAST;
                case (nxt.kind)
                    CMD_ITEM:
                    begin
                        if (!(gap_ok && $urandom_range(0, 99) < GAP_PERCENT))
                        begin
                            opcode <= nxt.op;
                            entry_index <= nxt.idx;
                            value <= nxt.val;
                            nstart = 1'b1;
                            void'(pending_cmds.pop_front());
                        end
                    end
                    CMD_TABLE_LEN:
                    begin
                        if (quiet_cycles >= CFG_QUIET)
                        begin
                            table_length <= nxt.len;
                            shadow_length = nxt.len;
                            nwe = 1'b1;
                            void'(pending_cmds.pop_front());
                        end
                    end
                    default:
                    begin
                        if (!start && searches_sent == answers_seen)
                        begin
                            void'(pending_cmds.pop_front());
                        end
                    end
                endcase
            end
            start <= nstart;
            table_length_we <= nwe;
        end
    end

    always @(posedge clk)
    begin : result_mon
        answer_t exp_a;
        if (rst_n && done)
        begin
            if (answers_seen < searches_sent)
            begin
                exp_a = expected_answers.pop_front();
                answers_seen <= answers_seen + 1;
                if (found !== exp_a.hit || interval_index !== exp_a.pos)
                begin
                    flag_error($sformatf("key %0d: found %b index %0d, expected found %b index %0d",
                                         exp_a.key, found, interval_index, exp_a.hit, exp_a.pos));
                end
            end
            else
            begin
                flag_error($sformatf("result with no search pending: found %b index %0d",
                                     found, interval_index));
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((start && !busy) || done || table_length_we)
            begin
                stall_cycles <= 0;
            end
            else if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial
    begin
        int  n;
        int  len;
        bit  big_done;
        big_done = 1'b0;

        // directed: no-data key, zero length, single entry, extreme ends, falling, flat
        push_search(NO_DATA_CODE);
        push_ctrl(CMD_TABLE_LEN, 0);
        push_search(12345);
        push_ctrl(CMD_TABLE_LEN, 1);
        push_item(OP_WRITE, 0, 77);
        push_search(77);
        push_search(78);
        push_search(76);
        push_item(OP_WRITE, 0, NO_DATA_CODE);
        push_item(OP_WRITE, 1, MAX_CODE);
        push_ctrl(CMD_TABLE_LEN, 2);
        push_search(MAX_CODE);
        push_search(NO_DATA_CODE + 1);
        push_search(NO_DATA_CODE);
        push_search(0);
        push_item(OP_WRITE, 0, 300);
        push_item(OP_WRITE, 1, 200);
        push_item(OP_WRITE, 2, 100);
        push_ctrl(CMD_TABLE_LEN, 3);
        push_search(300);
        push_search(150);
        push_search(100);
        push_search(99);
        push_item(OP_WRITE, 0, 5);
        push_item(OP_WRITE, 1, 5);
        push_item(OP_WRITE, 2, 5);
        push_search(5);
        push_search(6);

        while (plan_items < ITEM_TARGET)
        begin
            if (!big_done && plan_items >= BIG_LOAD_AT)
            begin
                // full-depth table: largest length and saturation of the length register
                load_table(TABLE_DEPTH, $urandom_range(0, 1), $urandom_range(1, 2));
                push_ctrl(CMD_TABLE_LEN, TABLE_DEPTH);
                search_burst(25);
                push_ctrl(CMD_DRAIN, 0);
                search_burst(5);
                push_ctrl(CMD_TABLE_LEN, (1 << LEN_W) - 1);
                search_burst(12);
                push_ctrl(CMD_TABLE_LEN, $urandom_range(2, TABLE_DEPTH - 1));
                search_burst(10);
                big_done = 1'b1;
            end
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
            load_table(n, $urandom_range(0, 1), $urandom_range(0, 4));
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: len = n;
                6, 7: len = $urandom_range(0, n);
                8: len = big_done ? $urandom_range(0, (1 << LEN_W) - 1) : n;
                default: len = 0;
            endcase
            push_ctrl(CMD_TABLE_LEN, len);
            search_burst($urandom_range(6, 18));
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (pending_cmds.size() != 0 || start || table_length_we
               || searches_sent != answers_seen);
        repeat (END_CYCLES) @(negedge clk);

        if (expected_answers.size() != 0)
        begin
            flag_error($sformatf("%0d searches never answered", expected_answers.size()));
        end
        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
